>>> design/adc_to_wind_speed_pwl_core_assert.svh
// assertion macros for the adc to wind speed converter
`ifndef ADC_TO_WIND_SPEED_PWL_CORE_ASSERT_SVH
`define ADC_TO_WIND_SPEED_PWL_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AWS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/awspwl_pkg.sv
// shared types, constants and helpers for the adc to wind speed converter
package awspwl_pkg;

    localparam int Q_W        = 24;
    localparam int FRAC_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int VPC_W      = 32;
    localparam int PIU_W      = 5;
    localparam int MAX_POINTS = 16;
    localparam int PT_IDX_W   = $clog2(MAX_POINTS);
    localparam int PROD_W     = SAMPLE_W + VPC_W;
    localparam int DIFF_W     = Q_W + 1;
    localparam int MUL_W      = DIFF_W + Q_W;
    localparam int NUM_W      = MUL_W + 1;
    localparam int DEN_W      = DIFF_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STEPS  = Q_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = VPC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_VPC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PIU = CFG_IDX_W'(1);

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic [VPC_W-1:0] VPC_RST = VPC_W'(4294967);
    localparam logic [PIU_W-1:0] PIU_RST = PIU_W'(15);

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic signed [Q_W-1:0] volts;
        logic signed [Q_W-1:0] speed;
    } t_curve_entry;

    typedef struct packed {
        logic                  done;
        logic                  sat;
        logic signed [Q_W-1:0] quot;
    } t_div_res;

    // reset curve: entry i is i volts and 2i m/s
    function automatic t_curve_entry default_entry(input logic [PT_IDX_W-1:0] idx);
        t_curve_entry e;
        e.volts = Q_W'(idx) << FRAC_W;
        e.speed = Q_W'(idx) << (FRAC_W + 1);
        return e;
    endfunction

endpackage

>>> design/awspwl_ifs.sv
// valid/ready channel interfaces for input and result beats
interface awspwl_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     op;
    logic [awspwl_pkg::PT_IDX_W-1:0]          point_index;
    logic signed [awspwl_pkg::Q_W-1:0]        point_voltage;
    logic signed [awspwl_pkg::Q_W-1:0]        point_speed;
    logic signed [awspwl_pkg::SAMPLE_W-1:0]   adc_sample;

    modport source (output valid, op, point_index, point_voltage, point_speed, adc_sample,
                    input ready);
    modport sink (input valid, op, point_index, point_voltage, point_speed, adc_sample,
                  output ready);
endinterface

interface awspwl_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [awspwl_pkg::Q_W-1:0] voltage_out;
    logic signed [awspwl_pkg::Q_W-1:0] wind_speed;
    logic                              saturated;
    logic                              table_fault;

    modport source (output valid, voltage_out, wind_speed, saturated, table_fault,
                    input ready);
    modport sink (input valid, voltage_out, wind_speed, saturated, table_fault,
                  output ready);
endinterface

>>> design/awspwl_div.sv
// signed divider, truncating toward zero, saturating to q8.16, two bits a cycle
module awspwl_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [awspwl_pkg::NUM_W-1:0]    i_num,
    input  logic signed [awspwl_pkg::DEN_W-1:0]    i_den,
    output awspwl_pkg::t_div_res                   o_res
);

    typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_DONE} t_dstate;

    t_dstate                               r_state;
    logic                                  r_neg;
    logic                                  r_ovf;
    logic [awspwl_pkg::NUM_W-1:0]          r_mag_n;
    logic [awspwl_pkg::DEN_W-1:0]          r_mag_d;
    logic [awspwl_pkg::DEN_W-1:0]          r_rem;
    logic [awspwl_pkg::Q_W-1:0]            r_lo;
    logic [awspwl_pkg::DIV_CNT_W-1:0]      r_cnt;

    logic                                  w_ovf;
    logic [awspwl_pkg::DEN_W-1:0]          n_rem;
    logic [awspwl_pkg::Q_W-1:0]            n_lo;
    logic [awspwl_pkg::DEN_W:0]            v_t;
    logic [awspwl_pkg::DEN_W-1:0]          v_rem;
    logic [awspwl_pkg::Q_W-1:0]            v_lo;

    // quotient of 2^24 or more cannot fit
    assign w_ovf = r_mag_n >= awspwl_pkg::NUM_W'({r_mag_d, {awspwl_pkg::Q_W{1'b0}}});

    // restoring steps, msb first
    always_comb begin
        v_rem = r_rem;
        v_lo  = r_lo;
        v_t   = '0;
        for (int s = 0; s < awspwl_pkg::DIV_BITS; s++) begin
            v_t  = {v_rem, v_lo[awspwl_pkg::Q_W-1]};
            v_lo = {v_lo[awspwl_pkg::Q_W-2:0], 1'b0};
            if (v_t >= {1'b0, r_mag_d}) begin
                v_rem   = awspwl_pkg::DEN_W'(v_t - {1'b0, r_mag_d});
                v_lo[0] = 1'b1;
            end else begin
                v_rem = awspwl_pkg::DEN_W'(v_t);
            end
        end
        n_rem = v_rem;
        n_lo  = v_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_num[awspwl_pkg::NUM_W-1] ^ i_den[awspwl_pkg::DEN_W-1];
                        r_mag_n <= i_num[awspwl_pkg::NUM_W-1] ? -i_num : i_num;
                        r_mag_d <= i_den[awspwl_pkg::DEN_W-1] ? -i_den : i_den;
                        r_state <= D_PREP;
                    end
                end
                D_PREP: begin
                    r_ovf   <= w_ovf;
                    r_rem   <= awspwl_pkg::DEN_W'(r_mag_n[awspwl_pkg::NUM_W-1:awspwl_pkg::Q_W]);
                    r_lo    <= r_mag_n[awspwl_pkg::Q_W-1:0];
                    r_cnt   <= '0;
                    r_state <= w_ovf ? D_DONE : D_RUN;
                end
                D_RUN: begin
                    r_rem <= n_rem;
                    r_lo  <= n_lo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == awspwl_pkg::DIV_CNT_W'(awspwl_pkg::DIV_STEPS - 1)) begin
                        r_state <= D_DONE;
                    end
                end
                D_DONE: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    // sign and saturation of the magnitude quotient
    always_comb begin
        o_res.done = (r_state == D_DONE);
        o_res.sat  = 1'b0;
        o_res.quot = $signed(r_lo);
        if (r_ovf) begin
            o_res.sat  = 1'b1;
            o_res.quot = r_neg ? awspwl_pkg::Q_MIN : awspwl_pkg::Q_MAX;
        end else if (!r_neg) begin
            if (r_lo[awspwl_pkg::Q_W-1]) begin
                o_res.sat  = 1'b1;
                o_res.quot = awspwl_pkg::Q_MAX;
            end
        end else if (r_lo > awspwl_pkg::Q_MIN) begin
            o_res.sat  = 1'b1;
            o_res.quot = awspwl_pkg::Q_MIN;
        end else begin
            o_res.quot = -$signed(r_lo);
        end
    end

endmodule

>>> design/adc_to_wind_speed_pwl_core.sv
// top level: adc sample to wind speed through a piecewise linear curve
//
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          op, point_index, point_voltage, point_speed, adc_sample
//  o_out     out  valid/ready          voltage_out, wind_speed, saturated, table_fault
//  cfg       in   i_cfg_we (no wait)   i_cfg_idx, i_cfg_data
//
// a write beat is taken in the idle state, leaves the block idle and gives no result beat
// a convert beat runs through scaling, the segment scan and the divider before the next beat is taken,
//   the scan reading 1..15 entries (one memory read a cycle); an equal-abscissa segment skips the
//   radix-4 divider, and a quotient overflow shortens the divider's run
// one beat is in work at a time; a finished result waits in the output register while
//   the next beat is taken, and the block holds before loading it if that register is full
// reset is synchronous active low; curve entries read their reset value until written,
//   tracked by one valid bit per entry, so no clearing pass is needed
module adc_to_wind_speed_pwl_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    awspwl_in_if.sink                              i_in,
    awspwl_out_if.source                           o_out,
    input  logic                                   i_cfg_we,
    input  logic [awspwl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [awspwl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    `include "adc_to_wind_speed_pwl_core_assert.svh"

    localparam int FRAC_SH = awspwl_pkg::FRAC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_RD0,
        ST_GET0,
        ST_SCAN,
        ST_DIFF,
        ST_PROD,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                                    r_state;

    // configuration registers
    logic [awspwl_pkg::VPC_W-1:0]              r_vpc;
    logic [awspwl_pkg::PIU_W-1:0]              r_piu;

    // curve memory, one entry per breakpoint, with valid bits
    awspwl_pkg::t_curve_entry                  r_curve [awspwl_pkg::MAX_POINTS];
    logic [awspwl_pkg::MAX_POINTS-1:0]         r_valid;
    awspwl_pkg::t_curve_entry                  r_rd_data;
    logic                                      r_rd_valid;
    logic [awspwl_pkg::PT_IDX_W-1:0]           r_rd_addr;
    logic [awspwl_pkg::PT_IDX_W-1:0]           r_addr;

    // datapath
    logic signed [awspwl_pkg::SAMPLE_W-1:0]    r_sample;
    logic signed [awspwl_pkg::PROD_W-1:0]      r_prod;
    logic signed [awspwl_pkg::Q_W-1:0]         r_x;
    logic                                      r_vsat;
    logic signed [awspwl_pkg::Q_W-1:0]         r_x0;
    logic signed [awspwl_pkg::Q_W-1:0]         r_y0;
    logic signed [awspwl_pkg::Q_W-1:0]         r_x1;
    logic signed [awspwl_pkg::Q_W-1:0]         r_y1;
    logic [awspwl_pkg::PT_IDX_W-1:0]           r_k;
    logic signed [awspwl_pkg::DIFF_W-1:0]      r_d0;
    logic signed [awspwl_pkg::DIFF_W-1:0]      r_d1;
    logic signed [awspwl_pkg::DEN_W-1:0]       r_den;
    logic signed [awspwl_pkg::MUL_W-1:0]       r_p0;
    logic signed [awspwl_pkg::MUL_W-1:0]       r_p1;
    logic signed [awspwl_pkg::NUM_W-1:0]       r_num;
    logic signed [awspwl_pkg::Q_W-1:0]         r_wind;
    logic                                      r_wsat;
    logic                                      r_flt;

    // output register
    logic                                      r_out_valid;
    logic signed [awspwl_pkg::Q_W-1:0]         r_out_volt;
    logic signed [awspwl_pkg::Q_W-1:0]         r_out_wind;
    logic                                      r_out_sat;
    logic                                      r_out_flt;

    logic                                      w_in_acc;
    logic                                      w_wr_en;
    logic signed [awspwl_pkg::PROD_W-1:0]      w_prod;
    logic signed [awspwl_pkg::PROD_W-FRAC_SH-1:0] w_shift;
    logic                                      w_x_ovf;
    logic signed [awspwl_pkg::Q_W-1:0]         n_x;
    logic [awspwl_pkg::PIU_W-1:0]              w_n;
    logic [awspwl_pkg::PT_IDX_W-1:0]           w_last;
    awspwl_pkg::t_curve_entry                  w_ent;
    logic                                      w_stop;
    logic signed [awspwl_pkg::DIFF_W-1:0]      w_d0;
    logic signed [awspwl_pkg::DIFF_W-1:0]      w_d1;
    logic signed [awspwl_pkg::DEN_W-1:0]       w_den;
    logic signed [awspwl_pkg::MUL_W-1:0]       w_p0;
    logic signed [awspwl_pkg::MUL_W-1:0]       w_p1;
    logic signed [awspwl_pkg::NUM_W-1:0]       w_num;
    logic                                      w_div_start;
    awspwl_pkg::t_div_res                      w_div_res;

    // handshakes
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    // slots beyond the store are dropped
    assign w_wr_en     = w_in_acc && (i_in.op == awspwl_pkg::OP_WRITE)
                         && ({1'b0, i_in.point_index} < awspwl_pkg::PIU_W'(awspwl_pkg::MAX_POINTS));

    assign o_out.valid       = r_out_valid;
    assign o_out.voltage_out = r_out_volt;
    assign o_out.wind_speed  = r_out_wind;
    assign o_out.saturated   = r_out_sat;
    assign o_out.table_fault = r_out_flt;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpc <= awspwl_pkg::VPC_RST;
            r_piu <= awspwl_pkg::PIU_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                awspwl_pkg::CFG_VPC: r_vpc <= i_cfg_data;
                awspwl_pkg::CFG_PIU: r_piu <= awspwl_pkg::PIU_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // curve memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_curve[i_in.point_index] <= '{volts: i_in.point_voltage, speed: i_in.point_speed};
        end
        r_rd_data <= r_curve[r_addr];
        r_rd_addr <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_valid[i_in.point_index] <= 1'b1;
            end
            r_rd_valid <= r_valid[r_addr];
        end
    end

    // unwritten entries read as the reset curve
    assign w_ent = r_rd_valid ? r_rd_data : awspwl_pkg::default_entry(r_rd_addr);

    // sample times gain, q.32 product
    assign w_prod  = r_sample * $signed({1'b0, r_vpc});
    // arithmetic shift gives floor to q8.16
    assign w_shift = r_prod[awspwl_pkg::PROD_W-1:FRAC_SH];
    assign w_x_ovf = !((&w_shift[awspwl_pkg::PROD_W-FRAC_SH-1:awspwl_pkg::Q_W-1])
                       || !(|w_shift[awspwl_pkg::PROD_W-FRAC_SH-1:awspwl_pkg::Q_W-1]));
    assign n_x     = w_x_ovf ? (w_shift[awspwl_pkg::PROD_W-FRAC_SH-1] ? awspwl_pkg::Q_MIN
                                                                      : awspwl_pkg::Q_MAX)
                             : w_shift[awspwl_pkg::Q_W-1:0];

    // points in use clamped to 2..max
    always_comb begin
        if (r_piu < awspwl_pkg::PIU_W'(2)) begin
            w_n = awspwl_pkg::PIU_W'(2);
        end else if (r_piu > awspwl_pkg::PIU_W'(awspwl_pkg::MAX_POINTS)) begin
            w_n = awspwl_pkg::PIU_W'(awspwl_pkg::MAX_POINTS);
        end else begin
            w_n = r_piu;
        end
    end
    assign w_last = awspwl_pkg::PT_IDX_W'(w_n - 1'b1);

    // first upper abscissa above x, or the last segment in use
    assign w_stop = (r_x < w_ent.volts) || (r_k == w_last);

    // interpolation terms
    assign w_d0  = r_x - r_x0;
    assign w_d1  = r_x1 - r_x;
    assign w_den = r_x1 - r_x0;
    assign w_p1  = r_d0 * r_y1;
    assign w_p0  = r_d1 * r_y0;
    assign w_num = r_p0 + r_p1;

    assign w_div_start = (r_state == ST_START);

    awspwl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_res   (w_div_res)
    );

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            // a load in the finish state takes over the drain
            if (r_out_valid && o_out.ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_in.op == awspwl_pkg::OP_CONVERT)) begin
                        r_sample <= i_in.adc_sample;
                        r_state  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_x     <= n_x;
                    r_vsat  <= w_x_ovf;
                    r_addr  <= '0;
                    r_state <= ST_RD0;
                end
                ST_RD0: begin
                    // entry 0 being read
                    r_addr  <= r_addr + 1'b1;
                    r_state <= ST_GET0;
                end
                ST_GET0: begin
                    r_x0    <= w_ent.volts;
                    r_y0    <= w_ent.speed;
                    r_k     <= awspwl_pkg::PT_IDX_W'(1);
                    r_addr  <= r_addr + 1'b1;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    // w_ent is entry r_k, entry r_k + 1 is in flight
                    if (w_stop) begin
                        r_x1    <= w_ent.volts;
                        r_y1    <= w_ent.speed;
                        r_state <= ST_DIFF;
                    end else begin
                        r_x0   <= w_ent.volts;
                        r_y0   <= w_ent.speed;
                        r_k    <= r_k + 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_DIFF: begin
                    r_d0    <= w_d0;
                    r_d1    <= w_d1;
                    r_den   <= w_den;
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    r_p0    <= w_p0;
                    r_p1    <= w_p1;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_num <= w_num;
                    if (r_den == '0) begin
                        // equal abscissae: no division, speed forced to zero
                        r_wind  <= '0;
                        r_wsat  <= 1'b0;
                        r_flt   <= 1'b1;
                        r_state <= ST_FIN;
                    end else begin
                        r_flt   <= 1'b0;
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_res.done) begin
                        r_wind  <= w_div_res.quot;
                        r_wsat  <= w_div_res.sat;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // load only when the output register is free or draining
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_volt  <= r_x;
                        r_out_wind  <= r_wind;
                        r_out_sat   <= r_vsat || r_wsat;
                        r_out_flt   <= r_flt;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `AWS_ASSERT_IMP(a_fault_zero, o_out.valid && o_out.table_fault, o_out.wind_speed == '0, "fault beat carries nonzero speed")
    `AWS_ASSERT_IMP(a_div_den, w_div_start, r_den != '0, "divide started on a zero span")
    `AWS_ASSERT_IMP(a_scan_range, r_state == ST_SCAN, r_k <= w_last, "segment scan ran past the last point")
    `AWS_ASSERT_NXT(a_busy_after_conv, w_in_acc && (i_in.op == awspwl_pkg::OP_CONVERT), !i_in.ready, "input taken while converting")

endmodule
